### design/grs_pkg.sv
// Shared types and constants of the grid resampler.
package grs_pkg;

	localparam int FRAC_BITS   = 8;
	localparam int WEIGHT_BITS = 20;

	localparam int DEF_MAX_WIDTH  = 128;
	localparam int DEF_MAX_HEIGHT = 128;
	localparam int DEF_MAX_LEVELS = 4;

	localparam logic [1:0] M_NEAREST  = 2'd0;
	localparam logic [1:0] M_BILINEAR = 2'd1;
	localparam logic [1:0] M_BICUBIC  = 2'd2;

	localparam logic [1:0] REG_METHOD = 2'd0;
	localparam logic [1:0] REG_WIDTH  = 2'd1;
	localparam logic [1:0] REG_HEIGHT = 2'd2;
	localparam logic [1:0] REG_LEVELS = 2'd3;

	typedef struct packed {
		logic [1:0] method;
		logic [7:0] width;
		logic [7:0] height;
		logic [2:0] levels;
	} grs_cfg_t;

	typedef struct packed {
		logic       load_wr;
		logic       capture;
		logic       prep1;
		logic       prep2;
		logic       prep3;
		logic       issue;
		logic       load_out;
		logic [3:0] tap;
		logic [2:0] lev;
		logic       last;
	} grs_cmd_t;

	typedef struct packed {
		logic query_ok;
		logic out_free;
	} grs_stat_t;

	typedef enum logic [2:0] {
		S_IDLE, S_P1, S_P2, S_P3, S_TAP, S_DR1, S_DR2, S_FIN
	} grs_state_t;

endpackage

### design/grs_cfg.sv
// Configuration registers of the grid resampler.
module grs_cfg import grs_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data,
	output grs_cfg_t   cfg
);
	grs_cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.method <= M_BILINEAR;
			cfg_q.width  <= 8'd128;
			cfg_q.height <= 8'd128;
			cfg_q.levels <= 3'd1;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_METHOD: cfg_q.method <= cfg_data[1:0];
				REG_WIDTH:  cfg_q.width  <= cfg_data;
				REG_HEIGHT: cfg_q.height <= cfg_data;
				REG_LEVELS: cfg_q.levels <= cfg_data[2:0];
				default: ;
			endcase
		end
	end
endmodule

### design/grs_ctrl.sv
// Sequencing state machine of the grid resampler.
module grs_ctrl import grs_pkg::*; #(
	parameter int MAX_LEVELS = DEF_MAX_LEVELS
) (
	input  logic      clk,
	input  logic      arst_n,
	input  grs_cfg_t  cfg,
	input  logic      in_valid,
	output logic      in_ready,
	input  logic      op,
	input  grs_stat_t stat,
	output grs_cmd_t  cmd
);
	grs_state_t state_q, state_nx;
	logic [3:0] tap_q, tap_nx;
	logic [2:0] lev_q, lev_nx;
	logic [2:0] nlev;
	logic [4:0] ntaps;
	logic       last;

	assign nlev = (int'(cfg.levels) > MAX_LEVELS) ? 3'(MAX_LEVELS) : cfg.levels;
	assign last = (3'(lev_q + 3'd1) == nlev);

	always_comb begin
		case (cfg.method)
			M_BILINEAR: ntaps = 5'd4;
			M_BICUBIC:  ntaps = 5'd16;
			default:    ntaps = 5'd1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			tap_q   <= '0;
			lev_q   <= '0;
		end else begin
			state_q <= state_nx;
			tap_q   <= tap_nx;
			lev_q   <= lev_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		tap_nx   = tap_q;
		lev_nx   = lev_q;
		cmd      = '0;
		cmd.tap  = tap_q;
		cmd.lev  = lev_q;
		cmd.last = last;
		in_ready = (state_q == S_IDLE);
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					if (op) begin
						cmd.capture = 1'b1;
						state_nx    = S_P1;
					end else begin
						cmd.load_wr = 1'b1;
					end
				end
			end
			S_P1: begin
				cmd.prep1 = 1'b1;
				state_nx  = S_P2;
			end
			S_P2: begin
				cmd.prep2 = 1'b1;
				state_nx  = S_P3;
			end
			S_P3: begin
				cmd.prep3 = 1'b1;
				lev_nx    = '0;
				tap_nx    = '0;
				if (nlev == 3'd0) state_nx = S_IDLE;
				else state_nx = stat.query_ok ? S_TAP : S_FIN;
			end
			S_TAP: begin
				cmd.issue = 1'b1;
				if (tap_q == 4'(ntaps - 5'd1)) state_nx = S_DR1;
				else tap_nx = 4'(tap_q + 4'd1);
			end
			S_DR1: state_nx = S_DR2;
			S_DR2: state_nx = S_FIN;
			S_FIN: begin
				if (stat.out_free) begin
					cmd.load_out = 1'b1;
					if (last) begin
						state_nx = S_IDLE;
					end else begin
						lev_nx   = 3'(lev_q + 3'd1);
						tap_nx   = '0;
						state_nx = stat.query_ok ? S_TAP : S_FIN;
					end
				end
			end
			default: state_nx = S_IDLE;
		endcase
	end

`ifndef NO_ASSERTIONS
	a_tap_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_TAP |-> 5'(tap_q) < ntaps) else $error("tap beyond patch");
	a_query_start: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && op |=> state_q == S_P1) else $error("query not started");
`endif
endmodule

### design/grs_dpath.sv
// Sample store, weight generation, multiply-accumulate and result register.
module grs_dpath import grs_pkg::*; #(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
	parameter int MAX_LEVELS = DEF_MAX_LEVELS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  grs_cfg_t           cfg,
	input  grs_cmd_t           cmd,
	output grs_stat_t          stat,
	input  logic [6:0]         load_col,
	input  logic [6:0]         load_row,
	input  logic [1:0]         load_level,
	input  logic signed [15:0] sample_value,
	input  logic               sample_missing,
	input  logic signed [23:0] pos_x,
	input  logic signed [23:0] pos_y,
	input  logic               out_ready,
	output logic               out_valid,
	output logic signed [15:0] value,
	output logic               undefined,
	output logic [1:0]         level_index,
	output logic               last
);
	localparam int DEPTH = MAX_LEVELS * MAX_HEIGHT * MAX_WIDTH;
	localparam int ADW   = $clog2(DEPTH);
	localparam int CWD   = $clog2(MAX_WIDTH);
	localparam int RWD   = $clog2(MAX_HEIGHT);
	localparam int F     = FRAC_BITS;
	localparam int XW    = 24 - F + 2;
	localparam int NW    = 3 * F + 5;
	localparam int WW    = WEIGHT_BITS + 2;
	localparam int CSH   = 3 * F + 1 - WEIGHT_BITS;
	localparam int PW    = 2 * WW + 16;
	localparam int AW    = PW + 4;

	function automatic logic signed [WW-1:0] cubic_w(input logic signed [NW-1:0] n);
		logic [NW-1:0] mag;
		mag = n[NW-1] ? NW'(-n) : NW'(n);
		mag = (mag + (NW'(1) << (CSH - 1))) >> CSH;
		return n[NW-1] ? -$signed(WW'(mag)) : $signed(WW'(mag));
	endfunction

	function automatic logic signed [AW-1:0] rshift(input logic signed [AW-1:0] v,
			input int sh);
		logic [AW-1:0] mag;
		mag = v[AW-1] ? AW'(-v) : AW'(v);
		mag = (mag + (AW'(1) << (sh - 1))) >> sh;
		return v[AW-1] ? -$signed(mag) : $signed(mag);
	endfunction

	// store
	logic [16:0]    mem [DEPTH];
	logic [16:0]    rd_q;
	logic [ADW-1:0] wr_addr, rd_addr, addr;
	logic           load_ok, we;

	assign load_ok = (int'(load_col) < MAX_WIDTH) && (int'(load_row) < MAX_HEIGHT)
		&& (int'(load_level) < MAX_LEVELS);
	assign we      = cmd.load_wr && load_ok;
	assign wr_addr = ADW'((int'(load_level) * MAX_HEIGHT + int'(load_row)) * MAX_WIDTH
		+ int'(load_col));
	assign addr    = we ? wr_addr : rd_addr;

	always_ff @(posedge clk) begin
		if (we) mem[addr] <= {sample_missing, sample_value};
		else rd_q <= mem[addr];
	end

	// query set-up
	logic signed [23:0]    px_q, py_q;
	logic [F-1:0]          fx, fy, fx_q, fy_q;
	logic [2*F-1:0]        f2x_q, f2y_q;
	logic [3*F-1:0]        f3x_q, f3y_q;
	logic signed [XW-1:0]  x0, y0, rx, ry, wd, ht, bc, br;
	logic signed [24:0]    pxe, pye, mx, my;
	logic                  dx, dy, ok, ok_q, dx_q, dy_q;
	logic [CWD-1:0]        base_col_q;
	logic [RWD-1:0]        base_row_q;
	localparam logic signed [24:0] HALF = 25'(1 << (F - 1));

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			px_q <= pos_x;
			py_q <= pos_y;
		end
	end

	assign fx  = px_q[F-1:0];
	assign fy  = py_q[F-1:0];
	assign x0  = XW'(px_q >>> F);
	assign y0  = XW'(py_q >>> F);
	assign dx  = |fx;
	assign dy  = |fy;
	assign pxe = 25'(px_q);
	assign pye = 25'(py_q);
	assign mx  = (((pxe[24] ? -pxe : pxe) + HALF) >>> F);
	assign my  = (((pye[24] ? -pye : pye) + HALF) >>> F);
	assign rx  = XW'(pxe[24] ? -mx : mx);
	assign ry  = XW'(pye[24] ? -my : my);
	assign wd  = (int'(cfg.width) > MAX_WIDTH) ? XW'(MAX_WIDTH) : XW'(cfg.width);
	assign ht  = (int'(cfg.height) > MAX_HEIGHT) ? XW'(MAX_HEIGHT) : XW'(cfg.height);

	always_comb begin
		case (cfg.method)
			M_NEAREST: begin
				ok = (rx >= 0) && (rx < wd) && (ry >= 0) && (ry < ht);
				bc = rx;
				br = ry;
			end
			M_BILINEAR: begin
				ok = (x0 >= 0) && (XW'(x0 + XW'(dx)) < wd)
					&& (y0 >= 0) && (XW'(y0 + XW'(dy)) < ht);
				bc = x0;
				br = y0;
			end
			M_BICUBIC: begin
				ok = (x0 >= 1) && (XW'(x0 + 2) < wd) && (y0 >= 1) && (XW'(y0 + 2) < ht);
				bc = XW'(x0 - 1);
				br = XW'(y0 - 1);
			end
			default: begin
				ok = 1'b0;
				bc = '0;
				br = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ok_q <= 1'b0;
		else if (cmd.prep1) ok_q <= ok;
	end

	always_ff @(posedge clk) begin
		if (cmd.prep1) begin
			fx_q       <= fx;
			fy_q       <= fy;
			dx_q       <= dx;
			dy_q       <= dy;
			f2x_q      <= fx * fx;
			f2y_q      <= fy * fy;
			base_col_q <= CWD'(bc);
			base_row_q <= RWD'(br);
		end
		if (cmd.prep2) begin
			f3x_q <= f2x_q * fx_q;
			f3y_q <= f2y_q * fy_q;
		end
	end

	// weights
	logic signed [WW-1:0] wx_q [4];
	logic signed [WW-1:0] wy_q [4];
	logic signed [WW-1:0] wxn [4];
	logic signed [WW-1:0] wyn [4];
	logic signed [NW-1:0] sfx, sf2x, sf3x, sfy, sf2y, sf3y;

	assign sfx  = NW'(fx_q);
	assign sf2x = NW'(f2x_q);
	assign sf3x = NW'(f3x_q);
	assign sfy  = NW'(fy_q);
	assign sf2y = NW'(f2y_q);
	assign sf3y = NW'(f3y_q);

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			wxn[k] = '0;
			wyn[k] = '0;
		end
		case (cfg.method)
			M_BILINEAR: begin
				wxn[0] = WW'(1 << F) - WW'(fx_q);
				wxn[1] = WW'(fx_q);
				wyn[0] = WW'(1 << F) - WW'(fy_q);
				wyn[1] = WW'(fy_q);
			end
			M_BICUBIC: begin
				wxn[0] = cubic_w(-(sfx <<< (2 * F)) + (sf2x <<< (F + 1)) - sf3x);
				wxn[1] = cubic_w((NW'(1) <<< (3 * F + 1)) - 5 * (sf2x <<< F) + 3 * sf3x);
				wxn[2] = cubic_w((sfx <<< (2 * F)) + 4 * (sf2x <<< F) - 3 * sf3x);
				wxn[3] = cubic_w(-(sf2x <<< F) + sf3x);
				wyn[0] = cubic_w(-(sfy <<< (2 * F)) + (sf2y <<< (F + 1)) - sf3y);
				wyn[1] = cubic_w((NW'(1) <<< (3 * F + 1)) - 5 * (sf2y <<< F) + 3 * sf3y);
				wyn[2] = cubic_w((sfy <<< (2 * F)) + 4 * (sf2y <<< F) - 3 * sf3y);
				wyn[3] = cubic_w(-(sf2y <<< F) + sf3y);
			end
			default: begin
				wxn[0] = WW'(1);
				wyn[0] = WW'(1);
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.prep3) begin
			for (int k = 0; k < 4; k++) begin
				wx_q[k] <= wxn[k];
				wy_q[k] <= wyn[k];
			end
		end
	end

	// tap walk
	logic [1:0]     ti, tj;
	logic [1:0]     oc, orw;
	logic [CWD-1:0] col;
	logic [RWD-1:0] row;

	always_comb begin
		case (cfg.method)
			M_BILINEAR: begin
				ti  = {1'b0, cmd.tap[0]};
				tj  = {1'b0, cmd.tap[1]};
				oc  = {1'b0, cmd.tap[0] & dx_q};
				orw = {1'b0, cmd.tap[1] & dy_q};
			end
			M_BICUBIC: begin
				ti  = cmd.tap[1:0];
				tj  = cmd.tap[3:2];
				oc  = cmd.tap[1:0];
				orw = cmd.tap[3:2];
			end
			default: begin
				ti  = '0;
				tj  = '0;
				oc  = '0;
				orw = '0;
			end
		endcase
	end

	assign col     = CWD'(base_col_q + CWD'(oc));
	assign row     = RWD'(base_row_q + RWD'(orw));
	assign rd_addr = ADW'((int'(cmd.lev) * MAX_HEIGHT + int'(row)) * MAX_WIDTH + int'(col));

	logic signed [2*WW-1:0] wp_s1;
	logic signed [PW-1:0]   prod_s2;
	logic signed [AW-1:0]   acc_q;
	logic                   v_s1, v_s2, miss_q, first;

	assign first = cmd.issue && (cmd.tap == 4'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= cmd.issue;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		wp_s1   <= wx_q[ti] * wy_q[tj];
		prod_s2 <= wp_s1 * $signed(rd_q[15:0]);
		if (first) miss_q <= 1'b0;
		else if (v_s1 && rd_q[16]) miss_q <= 1'b1;
		if (first) acc_q <= '0;
		else if (v_s2) acc_q <= acc_q + AW'(prod_s2);
	end

	// rounding, saturation and result register
	logic signed [AW-1:0] rnd;
	logic signed [15:0]   sat;
	logic                 undef, out_valid_q;

	always_comb begin
		case (cfg.method)
			M_BILINEAR: rnd = rshift(acc_q, 2 * F);
			M_BICUBIC:  rnd = rshift(acc_q, 2 * WEIGHT_BITS);
			default:    rnd = acc_q;
		endcase
		if (rnd > AW'(32767)) sat = 16'sh7FFF;
		else if (rnd < -AW'(32768)) sat = -16'sh8000;
		else sat = 16'(rnd);
	end

	assign undef = !ok_q || miss_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (cmd.load_out) out_valid_q <= 1'b1;
		else if (out_ready) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			value       <= undef ? 16'sd0 : sat;
			undefined   <= undef;
			level_index <= cmd.lev[1:0];
			last        <= cmd.last;
		end
	end

	assign out_valid     = out_valid_q;
	assign stat.query_ok = ok_q;
	assign stat.out_free = !out_valid_q || out_ready;

`ifndef NO_ASSERTIONS
	a_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> $past(v_s1)) else $error("product without read");
	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid_q || out_ready)) else $error("result overwritten");
`endif
endmodule

### design/grid_resampler_unit.sv
// Top level of the grid resampler.
// Input channel (in_valid/in_ready): op 0 loads one sample into the store;
// op 1 queries position (pos_x, pos_y) and yields one result transaction
// per level in use, levels in ascending order, last set on the final one.
// A query passes set-up states P1, P2 and P3, then per level reads T taps in
// TAP (1 nearest, 4 bilinear, 16 bicubic), drains in DR1, DR2 and ends in FIN.
// Taps come one a cycle from the single-port sample store.
// A position outside the valid area skips the tap reads.
// in_ready is high only between queries; loads stream at one per cycle.
// Output channel (out_valid/out_ready) has a result register: the next level is
// computed while a result waits, and the block waits if the receiver stalls.
// Configuration (cfg_valid/cfg_ready, cfg_index, cfg_data) is always ready; the
// user must write it only while the block is idle; the block does not enforce it.
// Reset restores the register defaults; the store is not cleared and must be
// loaded before it is read.
module grid_resampler_unit import grs_pkg::*; #(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
	parameter int MAX_LEVELS = DEF_MAX_LEVELS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [7:0]         cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               op,
	input  logic [6:0]         load_col,
	input  logic [6:0]         load_row,
	input  logic [1:0]         load_level,
	input  logic signed [15:0] sample_value,
	input  logic               sample_missing,
	input  logic signed [23:0] pos_x,
	input  logic signed [23:0] pos_y,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] value,
	output logic               undefined,
	output logic [1:0]         level_index,
	output logic               last
);
	grs_cfg_t  cfg;
	grs_cmd_t  cmd;
	grs_stat_t stat;

	grs_cfg u_cfg (
		.clk, .arst_n, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data, .cfg
	);

	grs_ctrl #(.MAX_LEVELS(MAX_LEVELS)) u_ctrl (
		.clk, .arst_n, .cfg, .in_valid, .in_ready, .op, .stat, .cmd
	);

	grs_dpath #(
		.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .MAX_LEVELS(MAX_LEVELS)
	) u_dpath (
		.clk, .arst_n, .cfg, .cmd, .stat, .load_col, .load_row, .load_level,
		.sample_value, .sample_missing, .pos_x, .pos_y, .out_ready, .out_valid,
		.value, .undefined, .level_index, .last
	);
endmodule
